// ===== rtl/bdsl_pkg.sv =====
// package for the button debouncer with short and long press detection
// holds codes, register indexes, reset values and the lane status type
// no dependencies
`default_nettype none

package bdsl_pkg;

  // number of buttons handled side by side
  localparam int unsigned NumButtonsDefault = 3;

  // field widths fixed by the item format
  localparam int unsigned FuncW  = 2;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 4;

  // configuration register reset values
  localparam logic [CfgW-1:0] DebounceReset  = 16'd50;
  localparam logic [CfgW-1:0] LongPressReset = 16'd1000;

  // item function codes
  typedef enum logic [FuncW-1:0] {
    FUNC_POLL      = 2'd0,
    FUNC_POP_SHORT = 2'd1,
    FUNC_POP_LONG  = 2'd2
  } func_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE   = 4'd0,
    REG_LONG_PRESS = 4'd1
  } cfg_reg_e;

  // what one lane reports for the item being transferred
  typedef struct packed {
    logic stable;
    logic ev_short;
    logic ev_long;
  } lane_status_t;

endpackage

`default_nettype wire

// ===== rtl/bdsl_if.sv =====
// channel interfaces of the debouncer: input items, result items, config writes
// depends on bdsl_pkg for field widths
`default_nettype none

interface bdsl_in_if #(
  parameter int unsigned NumButtons = bdsl_pkg::NumButtonsDefault
);
  logic                          valid;
  logic                          ready;
  logic [bdsl_pkg::FuncW-1:0]    func;
  logic [bdsl_pkg::TimeW-1:0]    now_time;
  logic [NumButtons-1:0]         raw_levels;

  modport source (output valid, func, now_time, raw_levels, input ready);
  modport sink   (input valid, func, now_time, raw_levels, output ready);
endinterface

interface bdsl_out_if #(
  parameter int unsigned NumButtons = bdsl_pkg::NumButtonsDefault,
  parameter int unsigned PopW       = $clog2(NumButtons + 1)
);
  logic                  valid;
  logic                  ready;
  logic [PopW-1:0]       popped_button;
  logic [NumButtons-1:0] stable_levels;
  logic [NumButtons-1:0] short_pending;
  logic [NumButtons-1:0] long_pending;

  modport source (output valid, popped_button, stable_levels, short_pending, long_pending,
                  input ready);
  modport sink   (input valid, popped_button, stable_levels, short_pending, long_pending,
                  output ready);
endinterface

interface bdsl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bdsl_pkg::CfgIdxW-1:0]  index;
  logic [bdsl_pkg::CfgW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bdsl_lane.sv =====
// one button lane: raw edge tracking, debounce timer and press timing
// depends on bdsl_pkg for widths and the lane status type
`default_nettype none

module bdsl_lane (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          poll_i,
  input  wire                          raw_i,
  input  wire [bdsl_pkg::TimeW-1:0]    now_i,
  input  wire [bdsl_pkg::CfgW-1:0]     debounce_i,
  input  wire [bdsl_pkg::CfgW-1:0]     long_press_i,
  output bdsl_pkg::lane_status_t       status_o
);

  logic                       last_raw_q, last_raw_d;
  logic                       stable_q, stable_d;
  logic [bdsl_pkg::TimeW-1:0] change_time_q, change_time_d;
  logic [bdsl_pkg::TimeW-1:0] press_time_q, press_time_d;
  logic                       press_valid_q, press_valid_d;
  logic [bdsl_pkg::TimeW-1:0] held;
  logic [bdsl_pkg::TimeW-1:0] duration;
  logic                       settle;
  logic                       ev_short, ev_long;

  // next lane state for a poll transfer
  always_comb begin
    last_raw_d    = last_raw_q;
    change_time_d = change_time_q;
    stable_d      = stable_q;
    press_time_d  = press_time_q;
    press_valid_d = press_valid_q;
    ev_short      = 1'b0;
    ev_long       = 1'b0;
    held          = '0;
    duration      = now_i - press_time_q;
    settle        = 1'b0;
    if (poll_i) begin
      // a raw change restarts the timer
      if (raw_i != last_raw_q) begin
        last_raw_d    = raw_i;
        change_time_d = now_i;
      end
      held   = now_i - change_time_d;
      settle = (held >= {{(bdsl_pkg::TimeW-bdsl_pkg::CfgW){1'b0}}, debounce_i}) &&
               (stable_q != last_raw_d);
      if (settle) begin
        stable_d = last_raw_d;
        if (last_raw_d) begin
          press_time_d  = now_i;
          press_valid_d = 1'b1;
        end
      end
      // release of a recorded press classifies it
      if (!stable_d && press_valid_q) begin
        if (duration >= {{(bdsl_pkg::TimeW-bdsl_pkg::CfgW){1'b0}}, long_press_i}) begin
          ev_long = 1'b1;
        end else begin
          ev_short = 1'b1;
        end
        press_valid_d = 1'b0;
      end
    end
  end

  // lane state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q    <= 1'b0;
      stable_q      <= 1'b0;
      change_time_q <= '0;
      press_time_q  <= '0;
      press_valid_q <= 1'b0;
    end else begin
      last_raw_q    <= last_raw_d;
      stable_q      <= stable_d;
      change_time_q <= change_time_d;
      press_time_q  <= press_time_d;
      press_valid_q <= press_valid_d;
    end
  end

  assign status_o.stable   = stable_d;
  assign status_o.ev_short = ev_short;
  assign status_o.ev_long  = ev_long;

endmodule

`default_nettype wire

// ===== rtl/bdsl_merge.sv =====
// merge stage: sticky event bits, lowest-pending pop and the result register
// depends on bdsl_pkg for function codes and the lane status type
`default_nettype none

module bdsl_merge #(
  parameter int unsigned NumButtons = bdsl_pkg::NumButtonsDefault,
  parameter int unsigned PopW       = $clog2(NumButtons + 1)
) (
  input  wire                                          clk_i,
  input  wire                                          rst_ni,
  input  wire                                          accept_i,
  input  wire [bdsl_pkg::FuncW-1:0]                    func_i,
  input  wire bdsl_pkg::lane_status_t [NumButtons-1:0] lanes_i,
  output logic                                         ready_o,
  bdsl_out_if.source                                   out_o
);

  logic [NumButtons-1:0] short_q, short_d;
  logic [NumButtons-1:0] long_q, long_d;
  logic [NumButtons-1:0] stable_all;
  logic [NumButtons-1:0] set_short, set_long;
  logic [NumButtons-1:0] pop_vec, pop_clear;
  logic                  found;
  logic [PopW-1:0]       popped;
  logic                  out_valid_q;
  logic [PopW-1:0]       popped_q;
  logic [NumButtons-1:0] stable_q, short_pend_q, long_pend_q;

  // gather lane reports
  always_comb begin
    for (int i = 0; i < NumButtons; i++) begin
      stable_all[i] = lanes_i[i].stable;
      set_short[i]  = lanes_i[i].ev_short;
      set_long[i]   = lanes_i[i].ev_long;
    end
  end

  // lowest pending button of the selected kind
  always_comb begin
    pop_vec = '0;
    unique case (bdsl_pkg::func_e'(func_i))
      bdsl_pkg::FUNC_POP_SHORT: pop_vec = short_q;
      bdsl_pkg::FUNC_POP_LONG:  pop_vec = long_q;
      default:                  pop_vec = '0;
    endcase
    found     = 1'b0;
    popped    = '0;
    pop_clear = '0;
    for (int i = 0; i < NumButtons; i++) begin
      if (pop_vec[i] && !found) begin
        found        = 1'b1;
        popped       = PopW'(i + 1);
        pop_clear[i] = 1'b1;
      end
    end
  end

  // sticky event update
  always_comb begin
    short_d = short_q;
    long_d  = long_q;
    if (accept_i) begin
      unique case (bdsl_pkg::func_e'(func_i))
        bdsl_pkg::FUNC_POLL: begin
          short_d = short_q | set_short;
          long_d  = long_q | set_long;
        end
        bdsl_pkg::FUNC_POP_SHORT: short_d = short_q & ~pop_clear;
        bdsl_pkg::FUNC_POP_LONG:  long_d  = long_q & ~pop_clear;
        default: begin
          short_d = short_q;
          long_d  = long_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= '0;
      long_q  <= '0;
    end else begin
      short_q <= short_d;
      long_q  <= long_d;
    end
  end

  // result register, refilled when empty or while the previous result is taken
  assign ready_o = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      popped_q     <= popped;
      stable_q     <= stable_all;
      short_pend_q <= short_d;
      long_pend_q  <= long_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.popped_button = popped_q;
  assign out_o.stable_levels = stable_q;
  assign out_o.short_pending = short_pend_q;
  assign out_o.long_pending  = long_pend_q;

endmodule

`default_nettype wire

// ===== rtl/button_debounce_short_long_press_top.sv =====
// Debouncer for NumButtons active-high buttons with short and long press events.
// One item is taken per clock while ready is high; its result is in the result
// register in the next cycle; one lane per button works on the poll in parallel,
// and the merge stage updates the sticky event bits and pops the lowest pending
// button. The input ready drops only while a result waits and the sink stalls.
// Configuration writes are always taken; an unknown register index is ignored.
// top level: config registers, button lanes and merge stage
// depends on bdsl_pkg, bdsl_if, bdsl_lane and bdsl_merge
`default_nettype none

module button_debounce_short_long_press_top #(
  parameter int unsigned NumButtons = bdsl_pkg::NumButtonsDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  bdsl_in_if.sink     in_i,
  bdsl_out_if.source  out_o,
  bdsl_cfg_if.sink    cfg_i
);

  logic [bdsl_pkg::CfgW-1:0]              debounce_q;
  logic [bdsl_pkg::CfgW-1:0]              long_press_q;
  logic                                   accept;
  logic                                   poll;
  logic                                   ready;
  bdsl_pkg::lane_status_t [NumButtons-1:0] lanes;

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= bdsl_pkg::DebounceReset;
      long_press_q <= bdsl_pkg::LongPressReset;
    end else if (cfg_i.valid) begin
      unique case (bdsl_pkg::cfg_reg_e'(cfg_i.index))
        bdsl_pkg::REG_DEBOUNCE:   debounce_q   <= cfg_i.data;
        bdsl_pkg::REG_LONG_PRESS: long_press_q <= cfg_i.data;
        default: begin
          debounce_q   <= debounce_q;
          long_press_q <= long_press_q;
        end
      endcase
    end
  end

  // input transfer
  assign in_i.ready = ready;
  assign accept     = in_i.valid && ready;
  assign poll       = accept && (bdsl_pkg::func_e'(in_i.func) == bdsl_pkg::FUNC_POLL);

  // one lane per button
  for (genvar g = 0; g < NumButtons; g++) begin : g_lane
    bdsl_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .poll_i       (poll),
      .raw_i        (in_i.raw_levels[g]),
      .now_i        (in_i.now_time),
      .debounce_i   (debounce_q),
      .long_press_i (long_press_q),
      .status_o     (lanes[g])
    );
  end

  // events, pop and result register
  bdsl_merge #(
    .NumButtons (NumButtons)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .func_i   (in_i.func),
    .lanes_i  (lanes),
    .ready_o  (ready),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

// ===== verif/button_debounce_short_long_press_top_tb.sv =====
`timescale 1ns / 1ps
// testbench for the three-button debouncer with short and long press events
// directed table then random polls and pops under several register settings
// depends on bdsl_pkg, bdsl_if and button_debounce_short_long_press_top

module button_debounce_short_long_press_top_tb;

  localparam int unsigned NumButtons = bdsl_pkg::NumButtonsDefault;
  localparam int unsigned FuncW      = bdsl_pkg::FuncW;
  localparam int unsigned TimeW      = bdsl_pkg::TimeW;
  localparam int unsigned CfgW       = bdsl_pkg::CfgW;
  localparam int unsigned CfgIdxW    = bdsl_pkg::CfgIdxW;
  localparam int unsigned PopW       = $clog2(NumButtons + 1);
  localparam int unsigned MaxIdle    = 17;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned SettleMax  = 2000;
  localparam int unsigned Latency    = 1;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned PhaseItems = 250;
  localparam int unsigned TimeoutNs  = 5_000_000;
  localparam logic [FuncW-1:0]   FuncUnused     = 2'd3;
  localparam logic [CfgIdxW-1:0] RegFirstUnused = CfgIdxW'(bdsl_pkg::REG_LONG_PRESS + 1);
  localparam bit Typed     = 1'b1;
  localparam bit Predicted = 1'b0;

  typedef struct packed {
    logic [PopW-1:0]       popped;
    logic [NumButtons-1:0] stable;
    logic [NumButtons-1:0] shorts;
    logic [NumButtons-1:0] longs;
  } button_report_t;

  typedef struct {
    logic [FuncW-1:0]      fn;
    logic [TimeW-1:0]      now;
    logic [NumButtons-1:0] raw;
    bit                    typed;
    button_report_t        want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  bdsl_in_if  #(.NumButtons(NumButtons)) in_ch ();
  bdsl_out_if #(.NumButtons(NumButtons)) out_ch ();
  bdsl_cfg_if cfg_ch ();

  button_debounce_short_long_press_top #(.NumButtons(NumButtons)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // tracked copy of the debouncer state
  logic [CfgW-1:0]       debounce_ms;
  logic [CfgW-1:0]       long_press_ms;
  logic [NumButtons-1:0] raw_seen;
  logic [NumButtons-1:0] stable_now;
  logic [NumButtons-1:0] press_open;
  logic [TimeW-1:0]      change_at [NumButtons];
  logic [TimeW-1:0]      press_at  [NumButtons];
  logic [NumButtons-1:0] short_flags;
  logic [NumButtons-1:0] long_flags;

  button_report_t expected_reports[$];
  stim_row_t      directed_rows[$];
  int unsigned    mismatch_count;
  bit             idle_on;
  bit             hold_req;
  logic [TimeW-1:0]      sim_ms;
  logic [NumButtons-1:0] held_raw;

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic button_report_t report_of(input int unsigned p, input int unsigned s,
                                               input int unsigned sh, input int unsigned lg);
    button_report_t r;
    r.popped = PopW'(p);
    r.stable = NumButtons'(s);
    r.shorts = NumButtons'(sh);
    r.longs  = NumButtons'(lg);
    return r;
  endfunction

  // apply one item to the tracked state and return the report it yields
  function automatic button_report_t advance_buttons(input logic [FuncW-1:0] fn,
                                                     input logic [TimeW-1:0] now,
                                                     input logic [NumButtons-1:0] raw);
    button_report_t r;
    logic [TimeW-1:0] held;
    bit found;
    int i;
    r = '0;
    found = 1'b0;
    if (fn == bdsl_pkg::FUNC_POLL) begin
      for (i = 0; i < NumButtons; i++) begin
        // raw edge restarts the debounce timer
        if (raw[i] != raw_seen[i]) begin
          raw_seen[i] = raw[i];
          change_at[i] = now;
        end
        held = now - change_at[i];
        if (held >= TimeW'(debounce_ms) && stable_now[i] != raw_seen[i]) begin
          stable_now[i] = raw_seen[i];
          if (stable_now[i]) begin
            press_at[i] = now;
            press_open[i] = 1'b1;
          end
        end
        // stable release closes the press and classifies it
        if (!stable_now[i] && press_open[i]) begin
          held = now - press_at[i];
          if (held >= TimeW'(long_press_ms)) long_flags[i] = 1'b1;
          else short_flags[i] = 1'b1;
          press_open[i] = 1'b0;
        end
      end
    end else if (fn == bdsl_pkg::FUNC_POP_SHORT || fn == bdsl_pkg::FUNC_POP_LONG) begin
      // lowest pending button of the selected kind
      for (i = 0; i < NumButtons; i++) begin
        if (!found &&
            ((fn == bdsl_pkg::FUNC_POP_SHORT) ? short_flags[i] : long_flags[i])) begin
          found = 1'b1;
          r.popped = PopW'(i + 1);
          if (fn == bdsl_pkg::FUNC_POP_SHORT) short_flags[i] = 1'b0;
          else long_flags[i] = 1'b0;
        end
      end
    end
    r.stable = stable_now;
    r.shorts = short_flags;
    r.longs  = long_flags;
    return r;
  endfunction

  // one item transfer on the input channel, with a random gap ahead of it
  task automatic send_item(input logic [FuncW-1:0] fn, input logic [TimeW-1:0] now,
                           input logic [NumButtons-1:0] raw, input bit typed,
                           input button_report_t want);
    int unsigned gap;
    button_report_t predicted;
    gap = idle_on ? $urandom_range(0, MaxIdle) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= fn;
    in_ch.now_time   <= now;
    in_ch.raw_levels <= raw;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = advance_buttons(fn, now, raw);
    expected_reports.push_back(typed ? want : predicted);
  endtask

  // mostly plausible button activity, some pops and some noise
  task automatic send_random_item();
    logic [FuncW-1:0]      fn;
    logic [TimeW-1:0]      now;
    logic [NumButtons-1:0] raw;
    int unsigned pick;
    int unsigned dm;
    int unsigned lm;
    int unsigned advance;
    dm = 32'(debounce_ms);
    lm = 32'(long_press_ms);
    pick = $urandom_range(0, 99);
    fn  = bdsl_pkg::FUNC_POLL;
    now = $urandom;
    raw = NumButtons'($urandom_range(0, 2**NumButtons - 1));
    if (pick < 12) begin
      fn = bdsl_pkg::FUNC_POP_SHORT;
    end else if (pick < 24) begin
      fn = bdsl_pkg::FUNC_POP_LONG;
    end else if (pick < 27) begin
      fn = FuncUnused;
    end else if (pick < 31) begin
      // time jump with arbitrary levels
      sim_ms = now;
    end else begin
      case ($urandom_range(0, 3))
        0: advance = $urandom_range(0, 3);
        1: advance = $urandom_range(0, dm + 2);
        2: advance = $urandom_range(dm, 2 * dm + 2);
        default: advance = $urandom_range(0, 2 * lm + 2);
      endcase
      sim_ms = sim_ms + advance;
      if ($urandom_range(0, 4) == 0) begin
        held_raw = NumButtons'($urandom_range(0, 2**NumButtons - 1));
      end
      raw = held_raw;
      // contact bounce on one button
      if ($urandom_range(0, 5) == 0) begin
        pick = $urandom_range(0, NumButtons - 1);
        raw[pick] = ~raw[pick];
      end
      now = sim_ms;
    end
    send_item(fn, now, raw, Predicted, '0);
  endtask

  // register write on the config channel
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    if (idx == bdsl_pkg::REG_DEBOUNCE) debounce_ms = val;
    else if (idx == bdsl_pkg::REG_LONG_PRESS) long_press_ms = val;
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering items and let all outstanding reports come back
  task automatic settle_results();
    int unsigned waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0 && waited < SettleMax) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_reports.size() != 0) begin
      $error("%0d expected reports never arrived", expected_reports.size());
      mismatch_count++;
      expected_reports.delete();
    end
    repeat (Latency + 3) @(posedge clk_i);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // result sink: random stalls, one long hold-off on request, field checks
  initial begin
    int unsigned stall;
    button_report_t want;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        stall = HoldCycles;
        hold_req = 1'b0;
      end else begin
        stall = idle_on ? $urandom_range(0, MaxIdle) : 0;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      if (expected_reports.size() == 0) begin
        $error("result transfer with no expected report");
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        compare_field("popped_button", 32'(want.popped), 32'(out_ch.popped_button));
        compare_field("stable_levels", 32'(want.stable), 32'(out_ch.stable_levels));
        compare_field("short_pending", 32'(want.shorts), 32'(out_ch.short_pending));
        compare_field("long_pending", 32'(want.longs), 32'(out_ch.long_pending));
      end
    end
  end

  // main sequence
  initial begin
    int unsigned phase;
    int unsigned n;
    logic [CfgW-1:0] deb_val;
    logic [CfgW-1:0] lp_val;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= bdsl_pkg::FUNC_POLL;
    in_ch.now_time   <= '0;
    in_ch.raw_levels <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= bdsl_pkg::REG_DEBOUNCE;
    cfg_ch.data      <= '0;
    rst_ni           <= 1'b0;
    debounce_ms   = bdsl_pkg::DebounceReset;
    long_press_ms = bdsl_pkg::LongPressReset;
    raw_seen      = '0;
    stable_now    = '0;
    press_open    = '0;
    short_flags   = '0;
    long_flags    = '0;
    foreach (change_at[i]) change_at[i] = '0;
    foreach (press_at[i]) press_at[i] = '0;
    mismatch_count = 0;
    idle_on  = 1'b1;
    hold_req = 1'b0;
    held_raw = '0;
    sim_ms   = '0;

    // after reset: nothing pending, unused selector, quiet poll
    directed_rows.push_back('{bdsl_pkg::FUNC_POP_SHORT, 32'd0, 3'd0, Typed,
                              report_of(0, 0, 0, 0)});
    directed_rows.push_back('{bdsl_pkg::FUNC_POP_LONG, 32'd0, 3'd0, Typed,
                              report_of(0, 0, 0, 0)});
    directed_rows.push_back('{FuncUnused, 32'hFFFF_FFFF, 3'd7, Typed, report_of(0, 0, 0, 0)});
    directed_rows.push_back('{bdsl_pkg::FUNC_POLL, 32'd0, 3'd0, Typed, report_of(0, 0, 0, 0)});
    // all pressed, one ms short of the debounce, then exactly on it
    directed_rows.push_back('{bdsl_pkg::FUNC_POLL, 32'd0, 3'd7, Predicted, '0});
    directed_rows.push_back('{bdsl_pkg::FUNC_POLL, 32'd49, 3'd7, Predicted, '0});
    directed_rows.push_back('{bdsl_pkg::FUNC_POLL, 32'd50, 3'd7, Predicted, '0});
    // short release on the first button, long release on the others
    directed_rows.push_back('{bdsl_pkg::FUNC_POLL, 32'd100, 3'd6, Predicted, '0});
    directed_rows.push_back('{bdsl_pkg::FUNC_POLL, 32'd150, 3'd6, Predicted, '0});
    directed_rows.push_back('{bdsl_pkg::FUNC_POLL, 32'd1050, 3'd0, Predicted, '0});
    directed_rows.push_back('{bdsl_pkg::FUNC_POLL, 32'd1100, 3'd0, Predicted, '0});
    directed_rows.push_back('{FuncUnused, 32'd0, 3'd0, Predicted, '0});
    directed_rows.push_back('{bdsl_pkg::FUNC_POP_LONG, 32'd0, 3'd0, Predicted, '0});
    directed_rows.push_back('{bdsl_pkg::FUNC_POP_SHORT, 32'd0, 3'd0, Predicted, '0});
    directed_rows.push_back('{bdsl_pkg::FUNC_POP_LONG, 32'd0, 3'd0, Predicted, '0});
    directed_rows.push_back('{bdsl_pkg::FUNC_POP_SHORT, 32'd0, 3'd0, Typed,
                              report_of(0, 0, 0, 0)});
    // press lasting exactly the long threshold
    directed_rows.push_back('{bdsl_pkg::FUNC_POLL, 32'd2000, 3'd1, Predicted, '0});
    directed_rows.push_back('{bdsl_pkg::FUNC_POLL, 32'd2050, 3'd1, Predicted, '0});
    directed_rows.push_back('{bdsl_pkg::FUNC_POLL, 32'd3000, 3'd0, Predicted, '0});
    directed_rows.push_back('{bdsl_pkg::FUNC_POLL, 32'd3049, 3'd0, Predicted, '0});
    directed_rows.push_back('{bdsl_pkg::FUNC_POLL, 32'd3050, 3'd0, Predicted, '0});
    // debounce across the timestamp wrap, press recorded at time zero
    directed_rows.push_back('{bdsl_pkg::FUNC_POLL, 32'hFFFF_FFCE, 3'd2, Predicted, '0});
    directed_rows.push_back('{bdsl_pkg::FUNC_POLL, 32'd0, 3'd2, Predicted, '0});
    directed_rows.push_back('{bdsl_pkg::FUNC_POLL, 32'd999, 3'd0, Predicted, '0});
    directed_rows.push_back('{bdsl_pkg::FUNC_POLL, 32'd1049, 3'd0, Predicted, '0});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].fn, directed_rows[k].now, directed_rows[k].raw,
                directed_rows[k].typed, directed_rows[k].want);
    end

    // register settings: extremes first, then random ones
    for (phase = 0; phase < NumPhases; phase++) begin
      settle_results();
      case (phase)
        0: begin deb_val = '0;         lp_val = '0;         end
        1: begin deb_val = '0;         lp_val = {CfgW{1'b1}}; end
        2: begin deb_val = {CfgW{1'b1}}; lp_val = '0;         end
        3: begin deb_val = {CfgW{1'b1}}; lp_val = {CfgW{1'b1}}; end
        4: begin
          deb_val = CfgW'($urandom_range(0, 200));
          lp_val  = CfgW'($urandom_range(0, 3000));
        end
        default: begin deb_val = CfgW'($urandom); lp_val = CfgW'($urandom); end
      endcase
      // writes to an unknown index must leave both registers alone
      write_register(CfgIdxW'($urandom_range(RegFirstUnused, 2**CfgIdxW - 1)),
                     CfgW'($urandom));
      write_register(bdsl_pkg::REG_DEBOUNCE, deb_val);
      write_register(bdsl_pkg::REG_LONG_PRESS, lp_val);
      sim_ms = $urandom_range(0, 1) ? 32'($urandom) :
               32'hFFFF_FFFF - 32'($urandom_range(0, 200000));
      for (n = 0; n < PhaseItems; n++) begin
        if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
        // back-to-back items against a long receiver hold-off
        if (phase == 1 && n == 0) begin
          idle_on  = 1'b0;
          hold_req = 1'b1;
        end
        send_random_item();
      end
    end

    settle_results();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TimeoutNs);
    $display("tb: failure");
    $finish;
  end

endmodule
